// ===== hdl/sobb_pkg.sv =====
// ----------------------------------------------------------------------------
// sobb_pkg
// Shared widths, pair tables and the square-root step for the segment versus
// oriented box overlap pipeline.
// ----------------------------------------------------------------------------
package sobb_pkg;

	localparam int IN_W     = 48;
	localparam int CW       = 16;                 // coordinate width (Q8.8)
	localparam int AF       = 14;                 // axis fraction bits
	localparam int AW       = AF + 2;             // axis component width
	localparam int XW       = IN_W + 3 * CW + 3 * AW;

	localparam int SUM_W    = CW + 2;             // s + e - 2c
	localparam int DIF_W    = CW + 1;             // e - s, s - c
	localparam int PM_W     = AW + SUM_W;
	localparam int PD_W     = AW + DIF_W;
	localparam int MM_W     = PM_W + 2;           // doubled midpoint projection
	localparam int DD_W     = PD_W + 2;           // doubled half direction projection

	localparam int H_LO     = MM_W / 2;           // split of the cross multiplies
	localparam int H_HI     = MM_W - H_LO;
	localparam int PROD_W   = MM_W + DD_W;
	localparam int LHS_W    = PROD_W + 2;
	localparam int RP_W     = CW + DD_W;
	localparam int RHS_W    = RP_W + 1;
	localparam int FACE_W   = ((CW + AF + 1 > MM_W) ? (CW + AF + 1) : MM_W) + 2;
	localparam int CMP_W    = ((LHS_W > RHS_W + AF + 1) ? LHS_W : (RHS_W + AF + 1)) + 2;

	localparam int SQ_W     = 2 * CW + 2;         // sum of squared offsets
	localparam int SQ_STEPS = SQ_W / 2;
	localparam int SQRT_STG = (SQ_STEPS + 1) / 2; // two root bits per stage
	localparam int HIT_DLY  = SQRT_STG - 4;
	localparam int LATENCY  = SQRT_STG + 4;

	localparam int DIST_W   = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// axis pairs of the three cross tests
	localparam int PAIR_I [3] = '{1, 2, 0};
	localparam int PAIR_J [3] = '{2, 0, 1};

	typedef struct packed {
		logic [SQ_W:0]   root;
		logic [SQ_W-1:0] rem;
	} sqrt_t;

	// one digit of the bitwise integer square root
	function automatic sqrt_t sqrt_step(sqrt_t x, int j);
		logic [SQ_W:0] bitv;
		logic [SQ_W:0] trial;
		sqrt_t         y;
		bitv  = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * j);
		trial = x.root + bitv;
		y     = x;
		if ({1'b0, x.rem} >= trial) begin
			y.rem  = x.rem - trial[SQ_W-1:0];
			y.root = (x.root >> 1) + bitv;
		end else begin
			y.root = x.root >> 1;
		end
		return y;
	endfunction

endpackage

// ===== hdl/sobb_proj.sv =====
// ----------------------------------------------------------------------------
// sobb_proj
// Stages 1 to 3: unpack and differences, projection products on the box axes,
// and sums of the projections and of the squared start-to-center offset.
// ----------------------------------------------------------------------------
module sobb_proj (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [sobb_pkg::IN_W-1:0]     seg_start,
	input  logic [sobb_pkg::IN_W-1:0]     seg_end,
	input  logic [sobb_pkg::IN_W-1:0]     box_center,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_u,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_v,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_w,
	input  logic [sobb_pkg::IN_W-1:0]     half_extents,
	output logic                          out_valid,
	output logic signed [sobb_pkg::MM_W-1:0] mm [3],
	output logic signed [sobb_pkg::DD_W-1:0] dd [3],
	output logic [sobb_pkg::CW-1:0]       hl [3],
	output logic [sobb_pkg::SQ_W-1:0]     sq
);

	localparam int CW = sobb_pkg::CW;
	localparam int AW = sobb_pkg::AW;
	localparam int XW = sobb_pkg::XW;

	logic [XW-1:0] xs, xe, xc, xh;
	logic [XW-1:0] xa [3];

	logic signed [sobb_pkg::SUM_W-1:0] sm_c [3];
	logic signed [sobb_pkg::DIF_W-1:0] df_c [3];
	logic signed [sobb_pkg::DIF_W-1:0] dc_c [3];
	logic signed [AW-1:0]              a_c  [3][3];
	logic [CW-1:0]                     hl_c [3];

	logic                              vld_s1, vld_s2, vld_s3;
	logic signed [sobb_pkg::SUM_W-1:0] sm_s1 [3];
	logic signed [sobb_pkg::DIF_W-1:0] df_s1 [3];
	logic signed [sobb_pkg::DIF_W-1:0] dc_s1 [3];
	logic signed [AW-1:0]              a_s1  [3][3];
	logic [CW-1:0]                     hl_s1 [3], hl_s2 [3], hl_s3 [3];
	logic signed [sobb_pkg::PM_W-1:0]  pm_s2 [3][3];
	logic signed [sobb_pkg::PD_W-1:0]  pd_s2 [3][3];
	logic [sobb_pkg::SQ_W-1:0]         sqk_s2 [3];
	logic signed [sobb_pkg::MM_W-1:0]  mm_s3 [3];
	logic signed [sobb_pkg::DD_W-1:0]  dd_s3 [3];
	logic [sobb_pkg::SQ_W-1:0]         sq_s3;

	// unpack; bits past the word read as zero
	assign xs    = XW'(seg_start);
	assign xe    = XW'(seg_end);
	assign xc    = XW'(box_center);
	assign xh    = XW'(half_extents);
	assign xa[0] = XW'(box_axis_u);
	assign xa[1] = XW'(box_axis_v);
	assign xa[2] = XW'(box_axis_w);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sm_c[k] = sobb_pkg::SUM_W'($signed(xs[k*CW +: CW]))
				+ sobb_pkg::SUM_W'($signed(xe[k*CW +: CW]))
				- (sobb_pkg::SUM_W'($signed(xc[k*CW +: CW])) <<< 1);
			df_c[k] = sobb_pkg::DIF_W'($signed(xe[k*CW +: CW]))
				- sobb_pkg::DIF_W'($signed(xs[k*CW +: CW]));
			dc_c[k] = sobb_pkg::DIF_W'($signed(xs[k*CW +: CW]))
				- sobb_pkg::DIF_W'($signed(xc[k*CW +: CW]));
			hl_c[k] = xh[k*CW +: CW];
			for (int i = 0; i < 3; i++)
				a_c[i][k] = $signed(xa[i][k*AW +: AW]);
		end
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: differences; stage 2: products; stage 3: sums
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sm_s1[k] <= sm_c[k];
			df_s1[k] <= df_c[k];
			dc_s1[k] <= dc_c[k];
			hl_s1[k] <= hl_c[k];
			hl_s2[k] <= hl_s1[k];
			hl_s3[k] <= hl_s2[k];
			sqk_s2[k] <= $unsigned(sobb_pkg::SQ_W'(dc_s1[k]) * sobb_pkg::SQ_W'(dc_s1[k]));
			for (int i = 0; i < 3; i++) begin
				a_s1[i][k]  <= a_c[i][k];
				pm_s2[i][k] <= sobb_pkg::PM_W'(a_s1[i][k]) * sobb_pkg::PM_W'(sm_s1[k]);
				pd_s2[i][k] <= sobb_pkg::PD_W'(a_s1[i][k]) * sobb_pkg::PD_W'(df_s1[k]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			mm_s3[i] <= sobb_pkg::MM_W'(pm_s2[i][0]) + sobb_pkg::MM_W'(pm_s2[i][1])
				+ sobb_pkg::MM_W'(pm_s2[i][2]);
			dd_s3[i] <= sobb_pkg::DD_W'(pd_s2[i][0]) + sobb_pkg::DD_W'(pd_s2[i][1])
				+ sobb_pkg::DD_W'(pd_s2[i][2]);
		end
		sq_s3 <= sqk_s2[0] + sqk_s2[1] + sqk_s2[2];
	end

	assign out_valid = vld_s3;
	assign mm        = mm_s3;
	assign dd        = dd_s3;
	assign hl        = hl_s3;
	assign sq        = sq_s3;

endmodule

// ===== hdl/sobb_sat.sv =====
// ----------------------------------------------------------------------------
// sobb_sat
// Stages 4 to 8: face tests on the three box axes and the three cross-axis
// tests, exact on full-width integers.
// ----------------------------------------------------------------------------
module sobb_sat (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [sobb_pkg::MM_W-1:0] mm [3],
	input  logic signed [sobb_pkg::DD_W-1:0] dd [3],
	input  logic [sobb_pkg::CW-1:0]          hl [3],
	output logic                             out_valid,
	output logic                             hit
);

	localparam int MM_W = sobb_pkg::MM_W;
	localparam int DD_W = sobb_pkg::DD_W;
	localparam int H_LO = sobb_pkg::H_LO;
	localparam int H_HI = sobb_pkg::H_HI;

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic [MM_W-1:0]         amm_s4 [3];
	logic                    smm_s4 [3];
	logic [DD_W-1:0]         add_s4 [3];
	logic                    sdd_s4 [3];
	logic [DD_W-1:0]         ad_s4  [3];
	logic [sobb_pkg::CW-1:0] hl_s4  [3];

	logic                          face_ok_s5, face_ok_s6, face_ok_s7;
	logic [H_LO+DD_W-1:0]          lo_s5 [3][2];
	logic [H_HI+DD_W-1:0]          hi_s5 [3][2];
	logic                          sg_s5 [3][2], sg_s6 [3][2];
	logic [sobb_pkg::RP_W-1:0]     rp_s5 [3][2];
	logic [sobb_pkg::PROD_W-1:0]   p_s6  [3][2];
	logic [sobb_pkg::RHS_W-1:0]    rhs_s6 [3], rhs_s7 [3];
	logic signed [sobb_pkg::LHS_W-1:0] lhs_s7 [3];
	logic                          hit_s8;

	logic face_ok_c;
	logic rej_c;

	// face test: |2m| > 2L + |2d|, written with ad = |2d| + 1
	always_comb begin
		face_ok_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (sobb_pkg::FACE_W'(amm_s4[i]) >= (sobb_pkg::FACE_W'(hl_s4[i]) << (sobb_pkg::AF + 1))
				+ sobb_pkg::FACE_W'(ad_s4[i]))
				face_ok_c = 1'b0;
		end
	end

	// cross test: reject when |lhs| > rhs scaled
	always_comb begin
		logic signed [sobb_pkg::CMP_W-1:0] l;
		logic signed [sobb_pkg::CMP_W-1:0] r;
		rej_c = 1'b0;
		for (int x = 0; x < 3; x++) begin
			l = sobb_pkg::CMP_W'(lhs_s7[x]);
			r = $signed(sobb_pkg::CMP_W'(rhs_s7[x]) << (sobb_pkg::AF + 1));
			if ((l > r) || ((-l) > r))
				rej_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		// stage 4: magnitudes and signs
		for (int i = 0; i < 3; i++) begin
			smm_s4[i] <= mm[i][MM_W-1];
			amm_s4[i] <= mm[i][MM_W-1] ? $unsigned(-mm[i]) : $unsigned(mm[i]);
			sdd_s4[i] <= dd[i][DD_W-1];
			add_s4[i] <= dd[i][DD_W-1] ? $unsigned(-dd[i]) : $unsigned(dd[i]);
			ad_s4[i]  <= (dd[i][DD_W-1] ? $unsigned(-dd[i]) : $unsigned(dd[i])) + DD_W'(1);
			hl_s4[i]  <= hl[i];
		end
		// stage 5: face result, split partial products
		face_ok_s5 <= face_ok_c;
		for (int x = 0; x < 3; x++) begin
			lo_s5[x][0] <= (H_LO+DD_W)'(amm_s4[sobb_pkg::PAIR_I[x]][H_LO-1:0])
				* (H_LO+DD_W)'(add_s4[sobb_pkg::PAIR_J[x]]);
			hi_s5[x][0] <= (H_HI+DD_W)'(amm_s4[sobb_pkg::PAIR_I[x]][MM_W-1:H_LO])
				* (H_HI+DD_W)'(add_s4[sobb_pkg::PAIR_J[x]]);
			sg_s5[x][0] <= smm_s4[sobb_pkg::PAIR_I[x]] ^ sdd_s4[sobb_pkg::PAIR_J[x]];
			lo_s5[x][1] <= (H_LO+DD_W)'(amm_s4[sobb_pkg::PAIR_J[x]][H_LO-1:0])
				* (H_LO+DD_W)'(add_s4[sobb_pkg::PAIR_I[x]]);
			hi_s5[x][1] <= (H_HI+DD_W)'(amm_s4[sobb_pkg::PAIR_J[x]][MM_W-1:H_LO])
				* (H_HI+DD_W)'(add_s4[sobb_pkg::PAIR_I[x]]);
			sg_s5[x][1] <= smm_s4[sobb_pkg::PAIR_J[x]] ^ sdd_s4[sobb_pkg::PAIR_I[x]];
			rp_s5[x][0] <= sobb_pkg::RP_W'(hl_s4[sobb_pkg::PAIR_I[x]])
				* sobb_pkg::RP_W'(ad_s4[sobb_pkg::PAIR_J[x]]);
			rp_s5[x][1] <= sobb_pkg::RP_W'(hl_s4[sobb_pkg::PAIR_J[x]])
				* sobb_pkg::RP_W'(ad_s4[sobb_pkg::PAIR_I[x]]);
		end
		// stage 6: join partial products, bound sum
		face_ok_s6 <= face_ok_s5;
		for (int x = 0; x < 3; x++) begin
			for (int t = 0; t < 2; t++) begin
				p_s6[x][t]  <= (sobb_pkg::PROD_W'(hi_s5[x][t]) << H_LO)
					+ sobb_pkg::PROD_W'(lo_s5[x][t]);
				sg_s6[x][t] <= sg_s5[x][t];
			end
			rhs_s6[x] <= sobb_pkg::RHS_W'(rp_s5[x][0]) + sobb_pkg::RHS_W'(rp_s5[x][1]);
		end
		// stage 7: signed difference of the two products
		face_ok_s7 <= face_ok_s6;
		for (int x = 0; x < 3; x++) begin
			lhs_s7[x] <= (sg_s6[x][0] ? -$signed(sobb_pkg::LHS_W'(p_s6[x][0]))
					: $signed(sobb_pkg::LHS_W'(p_s6[x][0])))
				- (sg_s6[x][1] ? -$signed(sobb_pkg::LHS_W'(p_s6[x][1]))
					: $signed(sobb_pkg::LHS_W'(p_s6[x][1])));
			rhs_s7[x] <= rhs_s6[x];
		end
		// stage 8: verdict
		hit_s8 <= face_ok_s7 & ~rej_c;
	end

	assign out_valid = vld_s8;
	assign hit       = hit_s8;

endmodule

// ===== hdl/sobb_isqrt.sv =====
// ----------------------------------------------------------------------------
// sobb_isqrt
// Pipelined floor integer square root, two root bits per stage, with the
// result saturated to the distance width.
// ----------------------------------------------------------------------------
module sobb_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [sobb_pkg::SQ_W-1:0]     sq,
	output logic                          out_valid,
	output logic [sobb_pkg::DIST_W-1:0]   distance
);

	localparam int STG = sobb_pkg::SQRT_STG;

	sobb_pkg::sqrt_t st_s  [STG];
	sobb_pkg::sqrt_t nxt_c [STG];
	logic            vld_s [STG];
	sobb_pkg::sqrt_t init_c;

	assign init_c.root = '0;
	assign init_c.rem  = sq;

	// digit steps of each stage
	always_comb begin
		sobb_pkg::sqrt_t x;
		for (int st = 0; st < STG; st++) begin
			x = (st == 0) ? init_c : st_s[(st == 0) ? 0 : st - 1];
			for (int t = 0; t < 2; t++) begin
				if (2 * st + t < sobb_pkg::SQ_STEPS)
					x = sobb_pkg::sqrt_step(x, 2 * st + t);
			end
			nxt_c[st] = x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < STG; st++)
				vld_s[st] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int st = 1; st < STG; st++)
				vld_s[st] <= vld_s[st-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int st = 0; st < STG; st++)
			st_s[st] <= nxt_c[st];
	end

	assign out_valid = vld_s[STG-1];
	assign distance = (st_s[STG-1].root > (sobb_pkg::SQ_W + 1)'(sobb_pkg::DIST_MAX))
		? sobb_pkg::DIST_MAX : st_s[STG-1].root[sobb_pkg::DIST_W-1:0];

endmodule

// ===== hdl/segment_obb_overlap_test.sv =====
// ----------------------------------------------------------------------------
// segment_obb_overlap_test
// Separating axis overlap test of a line segment against an oriented box.
// ----------------------------------------------------------------------------
// Use:
//   A word (segment, box center, axes, half lengths) is taken at a rising edge
//   with start high and busy low. busy stays low: a word can be taken in
//   every cycle.
//   Each result word (hit, start_distance) is shown for exactly one cycle
//   with done high. Results leave in input order, one per input word.
//   Latency is set by the root extraction, two root bits per stage over the
//   squared start-to-center distance; the axis tests run alongside it.
//   Throughput is one word per clock.
//   start_distance is 0 when hit is 0.
//   The receiver cannot stall; done must be taken when shown.
//   arst_n clears all valid bits at once; words in flight are dropped and
//   no done follows them.
// ----------------------------------------------------------------------------
module segment_obb_overlap_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sobb_pkg::IN_W-1:0]     seg_start,
	input  logic [sobb_pkg::IN_W-1:0]     seg_end,
	input  logic [sobb_pkg::IN_W-1:0]     box_center,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_u,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_v,
	input  logic [sobb_pkg::IN_W-1:0]     box_axis_w,
	input  logic [sobb_pkg::IN_W-1:0]     half_extents,
	output logic                          done,
	output logic                          hit,
	output logic [sobb_pkg::DIST_W-1:0]   start_distance
);

	localparam int HD = sobb_pkg::HIT_DLY;

	logic                              in_valid;
	logic                              proj_vld;
	logic signed [sobb_pkg::MM_W-1:0]  mm [3];
	logic signed [sobb_pkg::DD_W-1:0]  dd [3];
	logic [sobb_pkg::CW-1:0]           hl [3];
	logic [sobb_pkg::SQ_W-1:0]         sq;
	logic                              sat_vld;
	logic                              sat_hit;
	logic                              rt_vld;
	logic [sobb_pkg::DIST_W-1:0]       rt_dist;

	logic [HD-1:0]                     hit_sr_q;
	logic                              done_q;
	logic [sobb_pkg::DIST_W-1:0]       dist_q;

	assign busy     = 1'b0;
	assign in_valid = start & ~busy;

	sobb_proj u_proj (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.seg_start    (seg_start),
		.seg_end      (seg_end),
		.box_center   (box_center),
		.box_axis_u   (box_axis_u),
		.box_axis_v   (box_axis_v),
		.box_axis_w   (box_axis_w),
		.half_extents (half_extents),
		.out_valid    (proj_vld),
		.mm           (mm),
		.dd           (dd),
		.hl           (hl),
		.sq           (sq)
	);

	sobb_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (proj_vld),
		.mm        (mm),
		.dd        (dd),
		.hl        (hl),
		.out_valid (sat_vld),
		.hit       (sat_hit)
	);

	sobb_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (proj_vld),
		.sq        (sq),
		.out_valid (rt_vld),
		.distance  (rt_dist)
	);

	// strobe follows the root pipeline; axis verdict is the shorter path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rt_vld;
		end
	end

	// hit delay line lines the verdict up with the distance
	always_ff @(posedge clk) begin
		hit_sr_q[0] <= sat_hit & sat_vld;
		for (int k = 1; k < HD; k++)
			hit_sr_q[k] <= hit_sr_q[k-1];
		dist_q <= rt_dist;
	end

	assign done           = done_q;
	assign hit            = done_q & hit_sr_q[HD-1];
	assign start_distance = hit ? dist_q : '0;

endmodule

// ===== hdl/sobb_checker.sv =====
// ----------------------------------------------------------------------------
// sobb_sva
// Port-level checks of the overlap test: fixed latency, no spurious results,
// zero distance on a miss, busy never raised.
// ----------------------------------------------------------------------------
module sobb_sva (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        hit,
	input logic [sobb_pkg::DIST_W-1:0] start_distance
);

	// every accepted word gives a result after the pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(sobb_pkg::LATENCY) done)
		else $error("result missing after accepted word");

	// no result without a word accepted the latency before
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(sobb_pkg::LATENCY) !done)
		else $error("result with no accepted word");

	// a miss reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (start_distance == '0))
		else $error("nonzero distance on a miss");

	// block never holds off input
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind segment_obb_overlap_test sobb_sva u_sobb_sva (.*);

// ===== dv/sobb_checker.sv =====
// ----------------------------------------------------------------------------
// sobb_checker
// Watches the input and result channels of the segment/box overlap block,
// predicts hit and start distance for every accepted word and compares.
// ----------------------------------------------------------------------------
module sobb_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [sobb_pkg::IN_W-1:0]   seg_start,
	input  logic [sobb_pkg::IN_W-1:0]   seg_end,
	input  logic [sobb_pkg::IN_W-1:0]   box_center,
	input  logic [sobb_pkg::IN_W-1:0]   box_axis_u,
	input  logic [sobb_pkg::IN_W-1:0]   box_axis_v,
	input  logic [sobb_pkg::IN_W-1:0]   box_axis_w,
	input  logic [sobb_pkg::IN_W-1:0]   half_extents,
	input  logic                        done,
	input  logic                        hit,
	input  logic [sobb_pkg::DIST_W-1:0] start_distance,
	output int                          fail_count,
	output int                          pending,
	output int                          hits_seen,
	output int                          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W   = sobb_pkg::IN_W;
	localparam int CW     = sobb_pkg::CW;
	localparam int AW     = sobb_pkg::AW;
	localparam int AF     = sobb_pkg::AF;
	localparam int DIST_W = sobb_pkg::DIST_W;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} overlap_t;

	overlap_t expected_q[$];

	function automatic logic signed [63:0] coord(logic [IN_W-1:0] v, int k);
		logic [CW-1:0] c;
		c = v[k*CW +: CW];
		return 64'(signed'(c));
	endfunction

	function automatic logic signed [63:0] axis_comp(logic [IN_W-1:0] v, int k);
		logic [AW-1:0] c;
		c = v[k*AW +: AW];
		return 64'(signed'(c));
	endfunction

	function automatic logic signed [127:0] abs128(logic signed [127:0] a);
		return a < 0 ? -a : a;
	endfunction

	// exact separating axis prediction on wide signed integers
	function automatic overlap_t predict_overlap(
			logic [IN_W-1:0] ps, logic [IN_W-1:0] pe, logic [IN_W-1:0] pc,
			logic [IN_W-1:0] au, logic [IN_W-1:0] av, logic [IN_W-1:0] aw,
			logic [IN_W-1:0] he);
		logic signed [127:0] mid [3];
		logic signed [127:0] dir [3];
		logic signed [127:0] len [3];
		logic signed [127:0] adir [3];
		logic signed [127:0] lhs, rhs, ax, sq, d;
		logic [IN_W-1:0]     axes [3];
		logic [63:0]         root, rem, bitv;
		overlap_t            r;
		int                  a, b;
		axes = '{au, av, aw};
		r.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mid[i] = 0;
			dir[i] = 0;
			for (int k = 0; k < 3; k++) begin
				ax = axis_comp(axes[i], k);
				mid[i] += ax * (coord(ps, k) + coord(pe, k) - 2 * coord(pc, k));
				dir[i] += ax * (coord(pe, k) - coord(ps, k));
			end
			len[i] = 128'(he[i*CW +: CW]) << (AF + 1);
			if (abs128(mid[i]) > len[i] + abs128(dir[i]))
				r.hit = 1'b0;
			adir[i] = abs128(dir[i]) + 1;
		end
		// cross tests on pairs (v,w), (w,u), (u,v)
		for (int t = 0; t < 3; t++) begin
			a = (t + 1) % 3;
			b = (t + 2) % 3;
			lhs = abs128(mid[a] * dir[b] - mid[b] * dir[a]);
			rhs = len[a] * adir[b] + len[b] * adir[a];
			if (r.hit && lhs > rhs)
				r.hit = 1'b0;
		end
		r.distance = '0;
		if (r.hit) begin
			sq = 0;
			for (int k = 0; k < 3; k++) begin
				d = coord(ps, k) - coord(pc, k);
				sq += d * d;
			end
			rem = 64'(sq);
			root = 0;
			bitv = 64'(1) << 62;
			while (bitv > rem)
				bitv >>= 2;
			while (bitv != 0) begin
				if (rem >= root + bitv) begin
					rem -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			r.distance = root > 64'(sobb_pkg::DIST_MAX) ? sobb_pkg::DIST_MAX
				: root[DIST_W-1:0];
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		overlap_t want;
		if (!arst_n) begin
			fail_count   <= 0;
			hits_seen    <= 0;
			results_seen <= 0;
		end else begin
			// compare result before pushing this edge's word
			if (done) begin
				results_seen <= results_seen + 1;
				if (hit)
					hits_seen <= hits_seen + 1;
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, hit);
						fail_count <= fail_count + 1;
					end else if (start_distance !== want.distance) begin
						$error("start_distance: expected %0d, actual %0d",
							want.distance, start_distance);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_overlap(seg_start, seg_end, box_center,
					box_axis_u, box_axis_v, box_axis_w, half_extents));
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random segment/box words into the overlap block with
// random sender gaps; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W     = sobb_pkg::IN_W;
	localparam int CW       = sobb_pkg::CW;
	localparam int AW       = sobb_pkg::AW;
	localparam int AF       = sobb_pkg::AF;
	localparam int DIST_W   = sobb_pkg::DIST_W;
	localparam int LATENCY  = sobb_pkg::LATENCY;
	localparam int WATCHDOG = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [IN_W-1:0]   seg_start = '0, seg_end = '0, box_center = '0;
	logic [IN_W-1:0]   box_axis_u = '0, box_axis_v = '0, box_axis_w = '0;
	logic [IN_W-1:0]   half_extents = '0;
	logic              done, hit;
	logic [DIST_W-1:0] start_distance;
	int                fail_count, pending, hits_seen, results_seen;
	int                idle_cycles = 0;
	int                gap_pct = 0;
	int                words_sent = 0;

	always #5 clk = ~clk;

	segment_obb_overlap_test DUT (.*);

	sobb_checker u_checker (.*);

	// watchdog over cycles with no accepted word either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("[segment_obb_overlap_test] ERROR");
			$finish;
		end
	end

	function automatic logic [IN_W-1:0] pack3(int a, int b, int c, int w);
		logic [IN_W-1:0] v;
		v = '0;
		v = v | (IN_W'(a) & ((IN_W'(1) << w) - 1));
		v = v | ((IN_W'(b) & ((IN_W'(1) << w) - 1)) << w);
		v = v | ((IN_W'(c) & ((IN_W'(1) << w) - 1)) << (2 * w));
		return v;
	endfunction

	function automatic logic [IN_W-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic int small_coord();
		return $urandom_range(0, 2047) - 1024;
	endfunction

	// send one word, honoring the current gap rate
	task automatic send_word(logic [IN_W-1:0] ps, pe, pc, au, av, aw, he);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		seg_start <= ps; seg_end <= pe; box_center <= pc;
		box_axis_u <= au; box_axis_v <= av; box_axis_w <= aw;
		half_extents <= he;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// random word: mostly boxes near the segment, some raw noise
	task automatic send_random();
		int              kind, cx, cy, cz, one;
		logic [IN_W-1:0] au, av, aw;
		kind = $urandom_range(9);
		one = 1 << AF;
		if (kind < 2) begin
			send_word(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
				rand48());
		end else begin
			cx = small_coord(); cy = small_coord(); cz = small_coord();
			if (kind < 6) begin
				au = pack3(one, 0, 0, AW);
				av = pack3(0, one, 0, AW);
				aw = pack3(0, 0, one, AW);
			end else begin
				au = pack3($urandom_range(0, 2 * one) - one,
					$urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one, AW);
				av = pack3($urandom_range(0, 2 * one) - one,
					$urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one, AW);
				aw = pack3($urandom_range(0, 2 * one) - one,
					$urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one, AW);
			end
			send_word(pack3(cx + small_coord(), cy + small_coord(), cz + small_coord(), CW),
				pack3(cx + small_coord(), cy + small_coord(), cz + small_coord(), CW),
				pack3(cx, cy, cz, CW), au, av, aw,
				pack3($urandom_range(1200), $urandom_range(1200), $urandom_range(1200), CW));
		end
	endtask

	initial begin
		logic [IN_W-1:0] ident_u, ident_v, ident_w, ones, unit;
		ident_u = pack3(1 << AF, 0, 0, AW);
		ident_v = pack3(0, 1 << AF, 0, AW);
		ident_w = pack3(0, 0, 1 << AF, AW);
		ones = {IN_W{1'b1}};
		unit = pack3(256, 256, 256, CW);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: hits, misses, point test, extremes, saturation corners
		send_word('0, '0, '0, ident_u, ident_v, ident_w, unit);
		send_word(unit, unit, '0, ident_u, ident_v, ident_w, unit);
		send_word(pack3(2000, 0, 0, CW), pack3(2000, 0, 0, CW), '0,
			ident_u, ident_v, ident_w, unit);
		send_word(pack3(-2000, 0, 0, CW), pack3(2000, 0, 0, CW), '0,
			ident_u, ident_v, ident_w, unit);
		send_word(pack3(-2000, 600, 0, CW), pack3(2000, 600, 0, CW), '0,
			ident_u, ident_v, ident_w, unit);
		send_word(pack3(-600, -600, 0, CW), pack3(600, 600, 0, CW), '0,
			ident_u, ident_v, ident_w, pack3(10, 10, 10, CW));
		send_word(pack3(-700, 0, 300, CW), pack3(0, 700, 300, CW), '0,
			ident_u, ident_v, ident_w, unit);
		send_word(pack3(-32768, -32768, -32768, CW), pack3(32767, 32767, 32767, CW),
			pack3(32767, 32767, 32767, CW), ident_u, ident_v, ident_w, ones);
		send_word(pack3(32767, 32767, 32767, CW), pack3(32767, 32767, 32767, CW),
			pack3(-32768, -32768, -32768, CW), ident_u, ident_v, ident_w, ones);
		send_word(ones, ones, '0, ones, ones, ones, ones);
		send_word('0, ones, '0, '0, '0, '0, '0);
		send_word(ones, '0, ones, pack3(-32768, -32768, -32768, AW),
			pack3(32767, 32767, 32767, AW), pack3(-32768, 32767, 0, AW), ones);
		send_word(pack3(100, 0, 0, CW), pack3(100, 0, 0, CW), '0, '0, '0, '0, '0);

		// random phases: no gaps, 80 % gaps, 32 % gaps, then no gaps again
		for (int p = 0; p < 4; p++) begin
			gap_pct = (p == 1) ? 80 : (p == 2) ? 32 : 0;
			repeat (460) send_random();
		end
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		$display("Sent %0d segment/box words; %0d results checked, %0d hits.",
			words_sent, results_seen, hits_seen);
		if (fail_count == 0)
			$display("[segment_obb_overlap_test] OK");
		else
			$display("[segment_obb_overlap_test] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/sobb_pkg.sv
hdl/sobb_proj.sv
hdl/sobb_sat.sv
hdl/sobb_isqrt.sv
hdl/segment_obb_overlap_test.sv
hdl/sobb_checker.sv
dv/sobb_checker.sv
dv/tb_top.sv
